// ===== rtl/ets_pkg.sv =====
// ----------------------------------------------------------------------------
// ets_pkg: shared codes for the entity table
// Request opcodes, result status codes and configuration register indexes,
// plus the fixed widths of the external ports.
// ----------------------------------------------------------------------------
package ets_pkg;

  // Fixed port widths.
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int OP_W         = 2;
  localparam int ID_PORT_W    = 8;
  localparam int SIG_PORT_W   = 32;
  localparam int MEMB_PORT_W  = 4;
  localparam int COUNT_PORT_W = 9;
  localparam int STATUS_W     = 2;
  localparam int MAX_SYSTEMS  = 4;

  typedef logic [OP_W-1:0]      op_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Request opcodes.
  localparam op_t OP_CREATE  = 2'd0;
  localparam op_t OP_DESTROY = 2'd1;
  localparam op_t OP_SET     = 2'd2;
  localparam op_t OP_GET     = 2'd3;

  // Result status codes.
  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_NO_FREE  = 2'd1;
  localparam status_t STATUS_RANGE    = 2'd2;
  localparam status_t STATUS_NOT_LIVE = 2'd3;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_MASK_0 = 3'd0;
  localparam cfg_idx_t CFG_MASK_1 = 3'd1;
  localparam cfg_idx_t CFG_MASK_2 = 3'd2;
  localparam cfg_idx_t CFG_MASK_3 = 3'd3;
  localparam cfg_idx_t CFG_ENABLE = 3'd4;

endpackage

// ===== rtl/entity_table_with_system_match.sv =====
// ----------------------------------------------------------------------------
// entity_table_with_system_match: entity table with system membership
// Allocates entity identifiers in FIFO order, keeps a component signature and
// per-system membership bits for every entity, and counts live entities.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   cfg      in         cfg_wr_en             cfg_index, cfg_data
//   in       in         in_valid / in_stall   in_op, in_entity_id, in_signature_in
//   out      out        out_valid / out_stall out_id_out, out_signature_out,
//                                             out_membership, out_live_count,
//                                             out_status
//
// Each request reads the entity memory and the free queue at the accept edge
// and modifies and writes back in the write-back state.
// The single entity-memory read-modify-write path takes one request at a time.
// After reset a clearing pass zeroes the entity memory word by word;
// input beats are stalled until it ends, configuration writes are taken.
// A stalled output beat holds the request in its write-back cycle.
// ----------------------------------------------------------------------------
module entity_table_with_system_match #(
  parameter int ENTITY_COUNT   = 256,
  parameter int SIGNATURE_BITS = 32,
  parameter int SYSTEM_COUNT   = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration port
  input  logic                                 cfg_wr_en,
  input  logic [ets_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ets_pkg::CFG_DATA_W-1:0]       cfg_data,
  // Request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ets_pkg::OP_W-1:0]             in_op,
  input  logic [ets_pkg::ID_PORT_W-1:0]        in_entity_id,
  input  logic [ets_pkg::SIG_PORT_W-1:0]       in_signature_in,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ets_pkg::ID_PORT_W-1:0]        out_id_out,
  output logic [ets_pkg::SIG_PORT_W-1:0]       out_signature_out,
  output logic [ets_pkg::MEMB_PORT_W-1:0]      out_membership,
  output logic [ets_pkg::COUNT_PORT_W-1:0]     out_live_count,
  output logic [ets_pkg::STATUS_W-1:0]         out_status
);

  localparam int ID_W  = $clog2(ENTITY_COUNT);
  localparam int CNT_W = $clog2(ENTITY_COUNT + 1);
  localparam int CMP_W = ((ID_W > ets_pkg::ID_PORT_W) ? ID_W : ets_pkg::ID_PORT_W) + 1;
  localparam int SX_W  = (SIGNATURE_BITS > ets_pkg::SIG_PORT_W) ?
                         SIGNATURE_BITS : ets_pkg::SIG_PORT_W;
  localparam int OC_W  = (CNT_W > ets_pkg::COUNT_PORT_W) ? CNT_W : ets_pkg::COUNT_PORT_W;
  localparam int ENT_W = 1 + SYSTEM_COUNT + SIGNATURE_BITS;

  localparam logic [CMP_W-1:0] N_CMP   = CMP_W'(ENTITY_COUNT);
  localparam logic [CNT_W-1:0] N_CNT   = CNT_W'(ENTITY_COUNT);
  localparam logic [ID_W-1:0]  LAST_ID = ID_W'(ENTITY_COUNT - 1);

  // Controller states.
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  // Memories: entity word is {live, membership, signature}.
  logic [ENT_W-1:0] ent_mem   [ENTITY_COUNT];
  logic [ID_W-1:0]  queue_mem [ENTITY_COUNT];

  // Control state.
  logic [1:0]       state_r;
  logic [ID_W-1:0]  clr_idx_r;
  logic [ID_W-1:0]  head_r;
  logic [ID_W-1:0]  tail_r;
  logic             wrapped_r;
  logic [CNT_W-1:0] live_r;
  logic             out_valid_r;

  // Configuration registers.
  logic [ets_pkg::CFG_DATA_W-1:0]  mask_r [ets_pkg::MAX_SYSTEMS];
  logic [ets_pkg::MAX_SYSTEMS-1:0] enable_r;

  // Request held during write-back.
  ets_pkg::op_t               op_r;
  logic [CMP_W-1:0]           id_r;
  logic [SIGNATURE_BITS-1:0]  sig_r;
  logic                       qvalid_r;
  logic [ENT_W-1:0]           ent_rd_r;
  logic [ID_W-1:0]            q_rd_r;

  // Output payload registers.
  logic [ets_pkg::ID_PORT_W-1:0]    out_id_r;
  logic [ets_pkg::SIG_PORT_W-1:0]   out_sig_r;
  logic [ets_pkg::MEMB_PORT_W-1:0]  out_memb_r;
  logic [ets_pkg::COUNT_PORT_W-1:0] out_live_r;
  ets_pkg::status_t                 out_status_r;

  // Next-state and datapath signals.
  logic                       in_acc;
  logic                       done;
  logic [CMP_W-1:0]           in_id_x;
  logic [ID_W-1:0]            in_idx;
  logic [SX_W-1:0]            in_sig_x;
  logic                       e_live;
  logic [SYSTEM_COUNT-1:0]    e_memb;
  logic [SIGNATURE_BITS-1:0]  e_sig;
  logic [ID_W-1:0]            new_id;
  logic [ID_W-1:0]            id_idx;
  logic [SYSTEM_COUNT-1:0]    memb_calc;
  logic [CMP_W-1:0]           res_id;
  logic [SIGNATURE_BITS-1:0]  res_sig;
  logic [SYSTEM_COUNT-1:0]    res_memb;
  ets_pkg::status_t           res_status;
  logic [SX_W-1:0]            res_sig_x;
  logic [OC_W-1:0]            live_x;
  logic                       ent_we;
  logic [ID_W-1:0]            ent_wa;
  logic [ENT_W-1:0]           ent_wd;
  logic                       q_we;
  logic [ID_W-1:0]            head_nxt;
  logic [ID_W-1:0]            tail_nxt;
  logic                       wrapped_nxt;
  logic [CNT_W-1:0]           live_nxt;

  // Handshake.
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign done      = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;

  // Input widening and memory address.
  assign in_id_x  = CMP_W'(in_entity_id);
  assign in_idx   = in_id_x[ID_W-1:0];
  assign in_sig_x = SX_W'(in_signature_in);

  // Fields of the entity word read at accept.
  assign e_live = ent_rd_r[ENT_W-1];
  assign e_memb = ent_rd_r[SIGNATURE_BITS +: SYSTEM_COUNT];
  assign e_sig  = ent_rd_r[SIGNATURE_BITS-1:0];
  assign id_idx = id_r[ID_W-1:0];

  // Queue entries not yet rewritten by a destroy still hold their own index.
  assign new_id = qvalid_r ? q_rd_r : head_r;

  // Membership of the new signature against every enabled system.
  always_comb begin
    logic [SX_W-1:0]           mask_x;
    logic [SIGNATURE_BITS-1:0] mk;
    memb_calc = '0;
    for (int k = 0; k < SYSTEM_COUNT; k++) begin
      mask_x       = SX_W'(mask_r[k]);
      mk           = mask_x[SIGNATURE_BITS-1:0];
      memb_calc[k] = enable_r[k] && ((sig_r & mk) == mk);
    end
  end

  // Request execution and write-back selection.
  always_comb begin
    res_id      = id_r;
    res_sig     = '0;
    res_memb    = '0;
    res_status  = ets_pkg::STATUS_OK;
    ent_we      = 1'b0;
    ent_wa      = id_idx;
    ent_wd      = '0;
    q_we        = 1'b0;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    wrapped_nxt = wrapped_r;
    live_nxt    = live_r;
    priority if (op_r == ets_pkg::OP_CREATE) begin
      if (live_r == N_CNT) begin
        res_status = ets_pkg::STATUS_NO_FREE;
        res_id     = '0;
      end else begin
        res_id   = CMP_W'(new_id);
        head_nxt = (head_r == LAST_ID) ? '0 : head_r + 1'b1;
        live_nxt = live_r + 1'b1;
        ent_we   = done;
        ent_wa   = new_id;
        ent_wd   = {1'b1, {(ENT_W-1){1'b0}}};
      end
    end else if (id_r >= N_CMP) begin
      res_status = ets_pkg::STATUS_RANGE;
    end else if (!e_live) begin
      res_status = ets_pkg::STATUS_NOT_LIVE;
      res_sig    = e_sig;
      res_memb   = e_memb;
    end else begin
      unique case (op_r)
        ets_pkg::OP_DESTROY: begin
          ent_we      = done;
          q_we        = done;
          tail_nxt    = (tail_r == LAST_ID) ? '0 : tail_r + 1'b1;
          wrapped_nxt = wrapped_r || (tail_r == LAST_ID);
          live_nxt    = live_r - 1'b1;
        end
        ets_pkg::OP_SET: begin
          ent_we   = done;
          ent_wd   = {1'b1, memb_calc, sig_r};
          res_sig  = sig_r;
          res_memb = memb_calc;
        end
        default: begin
          res_sig  = e_sig;
          res_memb = e_memb;
        end
      endcase
    end
    // The clearing pass owns the entity write port.
    if (state_r == ST_CLEAR) begin
      ent_we = 1'b1;
      ent_wa = clr_idx_r;
      ent_wd = '0;
    end
  end

  assign res_sig_x = SX_W'(res_sig);
  assign live_x    = OC_W'(live_nxt);

  // Memories: read at accept, write at write-back or during clearing.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ent_rd_r <= ent_mem[in_idx];
      q_rd_r   <= queue_mem[head_r];
    end
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    if (q_we) begin
      queue_mem[tail_r] <= id_idx;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_op;
      id_r     <= in_id_x;
      sig_r    <= in_sig_x[SIGNATURE_BITS-1:0];
      qvalid_r <= wrapped_r || (head_r < tail_r);
    end
  end

  // Controller, queue pointers and live count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      wrapped_r <= 1'b0;
      live_r    <= '0;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == LAST_ID) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (done) begin
            state_r   <= ST_IDLE;
            head_r    <= head_nxt;
            tail_r    <= tail_nxt;
            wrapped_r <= wrapped_nxt;
            live_r    <= live_nxt;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_id_r     <= res_id[ets_pkg::ID_PORT_W-1:0];
      out_sig_r    <= res_sig_x[ets_pkg::SIG_PORT_W-1:0];
      out_memb_r   <= ets_pkg::MEMB_PORT_W'(res_memb);
      out_live_r   <= live_x[ets_pkg::COUNT_PORT_W-1:0];
      out_status_r <= res_status;
    end
  end

  assign out_id_out        = out_id_r;
  assign out_signature_out = out_sig_r;
  assign out_membership    = out_memb_r;
  assign out_live_count    = out_live_r;
  assign out_status        = out_status_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ets_pkg::MAX_SYSTEMS; k++) begin
        mask_r[k] <= '0;
      end
      enable_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ets_pkg::CFG_MASK_0: mask_r[0] <= cfg_data;
        ets_pkg::CFG_MASK_1: mask_r[1] <= cfg_data;
        ets_pkg::CFG_MASK_2: mask_r[2] <= cfg_data;
        ets_pkg::CFG_MASK_3: mask_r[3] <= cfg_data;
        ets_pkg::CFG_ENABLE: enable_r  <= cfg_data[ets_pkg::MAX_SYSTEMS-1:0];
        default: begin
        end
      endcase
    end
  end

  // The live count never exceeds the table size.
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= N_CNT)
    else $error("live count above table size");

  // With no entity live, or all of them, the queue pointers meet.
  a_queue_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (live_r == '0 || live_r == N_CNT) |-> head_r == tail_r)
    else $error("queue pointers disagree with live count");

  // An accepted beat always goes to write-back next.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_EXEC)
    else $error("accepted beat not executed");

  // A result appears only from a write-back cycle.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC))
    else $error("result without write-back");

endmodule

// ===== tb/entity_table_checker.sv =====
// ----------------------------------------------------------------------------
// entity_table_checker: result checker for the entity table
// Watches the configuration port and both channels, keeps its own model of
// the free queue, signatures, membership bits and live count, and compares
// every result beat field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module entity_table_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  ets_pkg::cfg_idx_t                  cfg_index,
  input  logic [ets_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  ets_pkg::op_t                       in_op,
  input  logic [ets_pkg::ID_PORT_W-1:0]      in_entity_id,
  input  logic [ets_pkg::SIG_PORT_W-1:0]     in_signature_in,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [ets_pkg::ID_PORT_W-1:0]      out_id_out,
  input  logic [ets_pkg::SIG_PORT_W-1:0]     out_signature_out,
  input  logic [ets_pkg::MEMB_PORT_W-1:0]    out_membership,
  input  logic [ets_pkg::COUNT_PORT_W-1:0]   out_live_count,
  input  ets_pkg::status_t                   out_status,
  output int unsigned                        fail_count,
  output int unsigned                        pending_count
);

  localparam int TABLE_SIZE     = 256;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [ets_pkg::ID_PORT_W-1:0]    id;
    logic [ets_pkg::SIG_PORT_W-1:0]   signature;
    logic [ets_pkg::MEMB_PORT_W-1:0]  membership;
    logic [ets_pkg::COUNT_PORT_W-1:0] live;
    ets_pkg::status_t                 status;
  } entity_result_t;

  // Model of the table contents and the configuration registers.
  logic [ets_pkg::ID_PORT_W-1:0]    free_ring [TABLE_SIZE];
  logic [ets_pkg::ID_PORT_W-1:0]    ring_head;
  logic [ets_pkg::ID_PORT_W-1:0]    ring_tail;
  logic [ets_pkg::COUNT_PORT_W-1:0] live_total;
  logic [ets_pkg::SIG_PORT_W-1:0]   sig_mem [TABLE_SIZE];
  logic [ets_pkg::MEMB_PORT_W-1:0]  memb_mem [TABLE_SIZE];
  logic                             alive [TABLE_SIZE];
  logic [ets_pkg::SIG_PORT_W-1:0]   req_mask [ets_pkg::MAX_SYSTEMS];
  logic [ets_pkg::MAX_SYSTEMS-1:0]  sys_enable;

  entity_result_t expected_results [$];
  int unsigned    mismatch_total = 0;

  // A system matches when it is enabled and the signature covers its mask.
  function automatic logic [ets_pkg::MEMB_PORT_W-1:0] match_systems(
      input logic [ets_pkg::SIG_PORT_W-1:0] sig);
    logic [ets_pkg::MEMB_PORT_W-1:0] bits;
    bits = '0;
    for (int k = 0; k < ets_pkg::MAX_SYSTEMS; k++) begin
      if (sys_enable[k] && ((sig & req_mask[k]) == req_mask[k])) bits[k] = 1'b1;
    end
    return bits;
  endfunction

  // Applies one request to the model and returns the result it should give.
  function automatic entity_result_t predict_request(
      input ets_pkg::op_t op,
      input logic [ets_pkg::ID_PORT_W-1:0] id,
      input logic [ets_pkg::SIG_PORT_W-1:0] sig);
    entity_result_t r;
    logic [ets_pkg::ID_PORT_W-1:0] slot;
    r        = '0;
    r.id     = id;
    r.status = ets_pkg::STATUS_OK;
    if (op == ets_pkg::OP_CREATE) begin
      if (int'(live_total) >= TABLE_SIZE) begin
        r.status = ets_pkg::STATUS_NO_FREE;
        r.id     = '0;
      end else begin
        slot         = free_ring[ring_head];
        ring_head    = ring_head + 1'b1;
        live_total   = live_total + 1'b1;
        alive[slot]  = 1'b1;
        r.id         = slot;
        r.signature  = sig_mem[slot];
        r.membership = memb_mem[slot];
      end
    end else if (int'(id) >= TABLE_SIZE) begin
      r.status = ets_pkg::STATUS_RANGE;
    end else if (!alive[id]) begin
      r.status     = ets_pkg::STATUS_NOT_LIVE;
      r.signature  = sig_mem[id];
      r.membership = memb_mem[id];
    end else begin
      if (op == ets_pkg::OP_DESTROY) begin
        sig_mem[id]          = '0;
        memb_mem[id]         = '0;
        alive[id]            = 1'b0;
        free_ring[ring_tail] = id;
        ring_tail            = ring_tail + 1'b1;
        if (live_total != 0) live_total = live_total - 1'b1;
      end else if (op == ets_pkg::OP_SET) begin
        sig_mem[id]  = sig;
        memb_mem[id] = match_systems(sig);
      end
      r.signature  = sig_mem[id];
      r.membership = memb_mem[id];
    end
    r.live = live_total;
    return r;
  endfunction

  task automatic flag_error(input string why, input entity_result_t want,
                            input entity_result_t got);
    mismatch_total++;
    if (mismatch_total <= REPORT_LIMIT) begin
      $display("entity table %s: expected id=%0d sig=%h memb=%b live=%0d status=%0d",
               why, want.id, want.signature, want.membership, want.live, want.status);
      $display("                  actual   id=%0d sig=%h memb=%b live=%0d status=%0d",
               got.id, got.signature, got.membership, got.live, got.status);
    end
  endtask

  // Everything is sampled at the rising edge, before the edge's updates land.
  always @(posedge clk) begin
    entity_result_t got;
    entity_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        free_ring[i] = i[ets_pkg::ID_PORT_W-1:0];
        sig_mem[i]   = '0;
        memb_mem[i]  = '0;
        alive[i]     = 1'b0;
      end
      for (int k = 0; k < ets_pkg::MAX_SYSTEMS; k++) req_mask[k] = '0;
      sys_enable = '0;
      ring_head  = '0;
      ring_tail  = '0;
      live_total = '0;
      expected_results.delete();
    end else begin
      // Track register writes so predictions use the live configuration.
      if (cfg_wr_en) begin
        case (cfg_index)
          ets_pkg::CFG_MASK_0: req_mask[0] = cfg_data;
          ets_pkg::CFG_MASK_1: req_mask[1] = cfg_data;
          ets_pkg::CFG_MASK_2: req_mask[2] = cfg_data;
          ets_pkg::CFG_MASK_3: req_mask[3] = cfg_data;
          ets_pkg::CFG_ENABLE: sys_enable  = cfg_data[ets_pkg::MAX_SYSTEMS-1:0];
          default: ;
        endcase
      end

      // Request beat: predict its result.
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_request(in_op, in_entity_id, in_signature_in));
      end

      // Result beat: compare with the oldest prediction.
      if (out_valid && !out_stall) begin
        got = '{id: out_id_out, signature: out_signature_out, membership: out_membership,
                live: out_live_count, status: out_status};
        if (expected_results.size() == 0) begin
          flag_error("result beat with nothing pending", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) flag_error("result mismatch", want, got);
        end
      end
    end
    fail_count    <= mismatch_total;
    pending_count <= expected_results.size();
  end

endmodule

// ===== tb/entity_table_with_system_match_test.sv =====
// ----------------------------------------------------------------------------
// entity_table_with_system_match_test: testbench top for the entity table
// Drives configuration writes and request beats with random gaps and result
// stalls: a directed pass over free, live and full-table cases, then random
// phases under changing masks. A checker beside the block predicts and checks.
// ----------------------------------------------------------------------------
module entity_table_with_system_match_test;

  localparam int TABLE_SIZE   = 256;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_COUNT  = 10;
  localparam int PHASE_ITEMS  = 87;

  logic                             clk             = 1'b0;
  logic                             rst_n           = 1'b0;
  logic                             cfg_wr_en       = 1'b0;
  ets_pkg::cfg_idx_t                cfg_index       = ets_pkg::CFG_MASK_0;
  logic [ets_pkg::CFG_DATA_W-1:0]   cfg_data        = '0;
  logic                             in_valid        = 1'b0;
  ets_pkg::op_t                     in_op           = ets_pkg::OP_CREATE;
  logic [ets_pkg::ID_PORT_W-1:0]    in_entity_id    = '0;
  logic [ets_pkg::SIG_PORT_W-1:0]   in_signature_in = '0;
  logic                             out_stall       = 1'b0;

  logic                             in_stall;
  logic                             out_valid;
  logic [ets_pkg::ID_PORT_W-1:0]    out_id_out;
  logic [ets_pkg::SIG_PORT_W-1:0]   out_signature_out;
  logic [ets_pkg::MEMB_PORT_W-1:0]  out_membership;
  logic [ets_pkg::COUNT_PORT_W-1:0] out_live_count;
  ets_pkg::status_t                 out_status;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;

  // Steering copies: which identifiers are live, and the masks last written.
  logic [ets_pkg::ID_PORT_W-1:0]    free_ids [$];
  logic [ets_pkg::ID_PORT_W-1:0]    live_ids [$];
  logic [ets_pkg::SIG_PORT_W-1:0]   mask_copy [ets_pkg::MAX_SYSTEMS];
  int                               in_mode = 0;

  entity_table_with_system_match dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_entity_id(in_entity_id), .in_signature_in(in_signature_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_id_out(out_id_out),
    .out_signature_out(out_signature_out), .out_membership(out_membership),
    .out_live_count(out_live_count), .out_status(out_status)
  );

  entity_table_checker result_check (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_entity_id(in_entity_id), .in_signature_in(in_signature_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_id_out(out_id_out),
    .out_signature_out(out_signature_out), .out_membership(out_membership),
    .out_live_count(out_live_count), .out_status(out_status),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Gap length: none in a quiet stretch, otherwise mostly short, a few long.
  function automatic int gap_cycles(input int mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (roll < ((mode == 1) ? 60 : 25)) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Random identifier of port width.
  function automatic logic [ets_pkg::ID_PORT_W-1:0] rand_id();
    logic [31:0] word;
    word = $urandom;
    return word[ets_pkg::ID_PORT_W-1:0];
  endfunction

  // Random set of enable bits.
  function automatic logic [ets_pkg::MAX_SYSTEMS-1:0] rand_enable();
    logic [31:0] word;
    word = $urandom;
    return word[ets_pkg::MAX_SYSTEMS-1:0];
  endfunction

  // Result-side stalls, in stretches of changing intensity.
  int stall_left   = 0;
  int stall_mode   = 1;
  int segment_left = 0;
  always @(posedge clk) begin
    if (segment_left == 0) begin
      stall_mode   = $urandom_range(0, 2);
      segment_left = $urandom_range(20, 300);
    end else begin
      segment_left--;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left = gap_cycles(stall_mode);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               pending_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Writes all five registers plus one unused index, one write per edge.
  task automatic write_config(input logic [ets_pkg::SIG_PORT_W-1:0] m0,
                              input logic [ets_pkg::SIG_PORT_W-1:0] m1,
                              input logic [ets_pkg::SIG_PORT_W-1:0] m2,
                              input logic [ets_pkg::SIG_PORT_W-1:0] m3,
                              input logic [ets_pkg::MAX_SYSTEMS-1:0] enable_bits);
    ets_pkg::cfg_idx_t              reg_order [5];
    logic [ets_pkg::CFG_DATA_W-1:0] reg_values [5];
    logic [ets_pkg::CFG_DATA_W-1:0] enable_word;
    // Unused upper bits of the enable register carry random data.
    enable_word = $urandom;
    enable_word[ets_pkg::MAX_SYSTEMS-1:0] = enable_bits;
    reg_order  = '{ets_pkg::CFG_MASK_0, ets_pkg::CFG_MASK_1, ets_pkg::CFG_MASK_2,
                   ets_pkg::CFG_MASK_3, ets_pkg::CFG_ENABLE};
    reg_values = '{m0, m1, m2, m3, enable_word};
    for (int k = 0; k < 5; k++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= reg_order[k];
      cfg_data  <= reg_values[k];
      @(posedge clk);
    end
    cfg_index <= ets_pkg::cfg_idx_t'($urandom_range(int'(ets_pkg::CFG_ENABLE) + 1,
                                                    (1 << ets_pkg::CFG_IDX_W) - 1));
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mask_copy = '{m0, m1, m2, m3};
  endtask

  // Presents one request beat, waits for it to be taken, then maybe idles.
  task automatic send_req(input ets_pkg::op_t op, input logic [ets_pkg::ID_PORT_W-1:0] id,
                          input logic [ets_pkg::SIG_PORT_W-1:0] sig);
    int gap;
    int pos;
    in_valid        <= 1'b1;
    in_op           <= op;
    in_entity_id    <= id;
    in_signature_in <= sig;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == ets_pkg::OP_CREATE && free_ids.size() != 0)
      live_ids.push_back(free_ids.pop_front());
    if (op == ets_pkg::OP_DESTROY) begin
      pos = -1;
      for (int i = 0; i < live_ids.size(); i++) if (live_ids[i] == id) pos = i;
      if (pos >= 0) begin
        live_ids.delete(pos);
        free_ids.push_back(id);
      end
    end
    gap = gap_cycles(in_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops requests and waits until every result is back and the block settles.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Signatures built around the current masks so that covers both hit and miss.
  function automatic logic [ets_pkg::SIG_PORT_W-1:0] pick_signature();
    int k;
    k = $urandom_range(0, ets_pkg::MAX_SYSTEMS - 1);
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1, 2:    return mask_copy[k] | $urandom;
      3:       return (mask_copy[k] | $urandom) & ~(32'h1 << $urandom_range(0, 31));
      4:       return mask_copy[k];
      5:       return mask_copy[0] | mask_copy[1] | mask_copy[2] | mask_copy[3];
      6:       return '0;
      default: return '1;
    endcase
  endfunction

  // One random request; most address live entities, the rest any identifier.
  task automatic random_request(input int w_create, input int w_destroy, input int w_set);
    ets_pkg::op_t                  op;
    logic [ets_pkg::ID_PORT_W-1:0] id;
    int                            roll;
    roll = $urandom_range(0, 99);
    if (roll < w_create) op = ets_pkg::OP_CREATE;
    else if (roll < w_create + w_destroy) op = ets_pkg::OP_DESTROY;
    else if (roll < w_create + w_destroy + w_set) op = ets_pkg::OP_SET;
    else op = ets_pkg::OP_GET;
    if (live_ids.size() != 0 && $urandom_range(0, 9) < 8)
      id = live_ids[$urandom_range(0, live_ids.size() - 1)];
    else
      id = rand_id();
    send_req(op, id, pick_signature());
  endtask

  // Sparse random mask, so random signatures cover it now and then.
  function automatic logic [ets_pkg::SIG_PORT_W-1:0] sparse_mask();
    return $urandom & $urandom & $urandom;
  endfunction

  initial begin
    for (int i = 0; i < TABLE_SIZE; i++) free_ids.push_back(i[ets_pkg::ID_PORT_W-1:0]);
    mask_copy = '{default: '0};
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass: free entities, each operation, all four systems enabled.
    write_config('0, '1, 32'h0000_00FF, 32'h8000_0001, 4'hF);
    send_req(ets_pkg::OP_GET, 8'd0, $urandom);
    send_req(ets_pkg::OP_DESTROY, 8'd5, $urandom);
    send_req(ets_pkg::OP_SET, 8'd7, '1);
    send_req(ets_pkg::OP_CREATE, 8'hFF, $urandom);
    send_req(ets_pkg::OP_CREATE, 8'h00, $urandom);
    send_req(ets_pkg::OP_SET, 8'd0, '1);
    send_req(ets_pkg::OP_SET, 8'd1, '0);
    send_req(ets_pkg::OP_SET, 8'd1, 32'h0000_00FF);
    send_req(ets_pkg::OP_SET, 8'd1, 32'h8000_0001);
    send_req(ets_pkg::OP_GET, 8'd0, $urandom);
    send_req(ets_pkg::OP_DESTROY, 8'd0, $urandom);
    send_req(ets_pkg::OP_DESTROY, 8'd0, $urandom);
    send_req(ets_pkg::OP_GET, 8'd1, $urandom);
    send_req(ets_pkg::OP_GET, 8'hFF, $urandom);

    // Fill the table, then ask for more identifiers than exist.
    while (free_ids.size() != 0) send_req(ets_pkg::OP_CREATE, rand_id(), $urandom);
    send_req(ets_pkg::OP_CREATE, rand_id(), $urandom);
    send_req(ets_pkg::OP_CREATE, rand_id(), $urandom);
    send_req(ets_pkg::OP_DESTROY, 8'd128, $urandom);
    send_req(ets_pkg::OP_CREATE, rand_id(), $urandom);
    send_req(ets_pkg::OP_SET, 8'd128, 32'h8000_00FF);

    // Membership already held survives a mask and enable change until a set.
    wait_idle();
    write_config('1, '1, '1, '1, 4'h0);
    send_req(ets_pkg::OP_GET, 8'd1, $urandom);
    send_req(ets_pkg::OP_GET, 8'd128, $urandom);
    send_req(ets_pkg::OP_SET, 8'd1, '1);

    // Random phases under different register settings and op mixes.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_idle();
      in_mode = $urandom_range(0, 2);
      if (phase == 0) write_config('0, '0, '0, '0, 4'h0);
      else if (phase == 1) write_config('1, '1, '1, '1, 4'hF);
      else if (phase == 2) write_config('0, '0, '0, '0, 4'hF);
      else write_config(sparse_mask(), sparse_mask(), sparse_mask(), $urandom,
                        rand_enable());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case (phase % 3)
          0:       random_request(50, 15, 20);
          1:       random_request(15, 50, 20);
          default: random_request(25, 25, 30);
        endcase
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
